[src/pma_pkg.sv]
// Shared types, constants and limb helpers for the Poly1305 accumulator.
package pma_pkg;

   localparam int LIMBS       = 5;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [4:0][25:0] CLAMP = {26'h00fffff, 26'h3f03fff, 26'h3ffc0ff,
                                         26'h3ffff03, 26'h3ffffff};

   typedef logic [4:0][27:0] acc_type;
   typedef logic [4:0][28:0] coef_type;

   typedef enum logic [2:0] {
      REG_R_LOW  = 3'd0,
      REG_R_HIGH = 3'd1,
      REG_S_LOW  = 3'd2,
      REG_S_HIGH = 3'd3,
      REG_AEAD   = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_FIX,
      ST_RED1,
      ST_RED2,
      ST_RED3,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [127:0] data;
      logic         high_bit;
      logic         has_block;
      logic         last;
   } entry_type;

   typedef struct packed {
      coef_type     r;
      coef_type     r5;
      logic [127:0] s;
   } key_type;

   typedef struct packed {
      acc_type    l;
      logic [2:0] c;
   } chain_type;

   // 128-bit value into five radix-2^26 limbs
   function automatic acc_type split128(input logic [127:0] v);
      acc_type a;
      a[0] = {2'b0, v[25:0]};
      a[1] = {2'b0, v[51:26]};
      a[2] = {2'b0, v[77:52]};
      a[3] = {2'b0, v[103:78]};
      a[4] = {4'b0, v[127:104]};
      return a;
   endfunction

   function automatic chain_type carry_chain(input acc_type a);
      chain_type  res;
      logic [28:0] x;
      logic [2:0]  c;
      c = 3'd0;
      for (int i = 0; i < LIMBS; i++) begin
         x        = {1'b0, a[i]} + {26'b0, c};
         c        = x[28:26];
         res.l[i] = {2'b0, x[25:0]};
      end
      res.c = c;
      return res;
   endfunction

endpackage

[src/poly1305_mac_accumulator_top.sv]
// Top level of the Poly1305 accumulator: key registers, front, queue and back end.
//
// Input channel: push a 16-byte block with its byte count and last flag while
// req_full is low. Blocks of 1..15 bytes are padded per aead_mode; a count of
// zero without the last flag is dropped.
// Result channel: after a block marked last, a 128-bit tag appears; it is
// valid while rsp_empty is low and leaves on rsp_pop.
// Key and mode are to be written through the csr_ port (always ready) only while
// idle; the block itself does not enforce this. Each block with data passes
// through the back end: the multiply by r runs one limb row per cycle through
// five 28x29 multipliers, plus a fold step. A last block adds reduction and tag
// formation. The front queue keeps taking blocks while the back end works; when
// a tag waits unread and the next one is ready, the back end holds and the
// queue fills, then req_full rises.
// Reset clears the accumulator, the keys, the queue and the output; input is
// held off in the cycle after reset.
module poly1305_mac_accumulator_top #(
   parameter int QUEUE_DEPTH = pma_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [63:0] req_block_low,
   input  logic [63:0] req_block_high,
   input  logic [4:0]  req_byte_count,
   input  logic        req_last_block,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [63:0] rsp_tag_low,
   output logic [63:0] rsp_tag_high,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   logic [63:0]        r_low_ff, r_high_ff, s_low_ff, s_high_ff;
   logic               aead_ff;
   pma_pkg::key_type   key_ff, key_in;
   pma_pkg::acc_type   r_raw;
   pma_pkg::entry_type f_entry, q_entry;
   logic               q_full, q_push, q_pop, q_valid;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         r_low_ff  <= '0;
         r_high_ff <= '0;
         s_low_ff  <= '0;
         s_high_ff <= '0;
         aead_ff   <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            pma_pkg::REG_R_LOW:  r_low_ff  <= csr_data;
            pma_pkg::REG_R_HIGH: r_high_ff <= csr_data;
            pma_pkg::REG_S_LOW:  s_low_ff  <= csr_data;
            pma_pkg::REG_S_HIGH: s_high_ff <= csr_data;
            pma_pkg::REG_AEAD:   aead_ff   <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // clamped r and 5*r limbs
   always_comb begin
      r_raw = pma_pkg::split128({r_high_ff, r_low_ff});
      for (int i = 0; i < pma_pkg::LIMBS; i++) begin
         key_in.r[i]  = {3'b0, r_raw[i][25:0] & pma_pkg::CLAMP[i]};
         key_in.r5[i] = {key_in.r[i][26:0], 2'b00} + key_in.r[i];
      end
      key_in.s = {s_high_ff, s_low_ff};
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   pma_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_block_low  (req_block_low),
      .req_block_high (req_block_high),
      .req_byte_count (req_byte_count),
      .req_last_block (req_last_block),
      .aead_mode      (aead_ff),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_entry        (f_entry)
   );

   pma_queue #(
      .WIDTH ($bits(pma_pkg::entry_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (f_entry),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_entry)
   );

   pma_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_entry      (q_entry),
      .q_pop        (q_pop),
      .key          (key_ff),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_tag_low  (rsp_tag_low),
      .rsp_tag_high (rsp_tag_high)
   );

endmodule

[src/pma_queue.sv]
// Small register queue between the front and the back.
module pma_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/pma_front.sv]
// Input side: masks and pads each block and classifies it for the back end.
module pma_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [63:0]         req_block_low,
   input  logic [63:0]         req_block_high,
   input  logic [4:0]          req_byte_count,
   input  logic                req_last_block,
   input  logic                aead_mode,
   input  logic                q_full,
   output logic                q_push,
   output pma_pkg::entry_type  q_entry
);
   logic [127:0] raw;
   logic [4:0]   n;
   logic         pad;
   logic         seen_ff;

   assign raw      = {req_block_high, req_block_low};
   assign n        = (req_byte_count > 5'd16) ? 5'd16 : req_byte_count;
   assign pad      = (n < 5'd16) && !aead_mode;
   assign req_full = q_full || !seen_ff;

   always_comb begin
      for (int b = 0; b < 16; b++) begin
         if (5'(b) < n) begin
            q_entry.data[8*b +: 8] = raw[8*b +: 8];
         end else if (5'(b) == n && pad) begin
            q_entry.data[8*b +: 8] = 8'h01;
         end else begin
            q_entry.data[8*b +: 8] = 8'h00;
         end
      end
      q_entry.high_bit  = !pad;
      q_entry.has_block = (n != 5'd0);
      q_entry.last      = req_last_block;
      q_push = req_push && !req_full && (q_entry.has_block || req_last_block);
   end

   // hold off input right after reset so key registers settle
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else begin
         seen_ff <= 1'b1;
      end
   end

endmodule

[src/pma_back.sv]
// Back end: row-serial multiply by r mod 2^130-5, final reduction and tag output.
module pma_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  pma_pkg::entry_type q_entry,
   output logic               q_pop,
   input  pma_pkg::key_type   key,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [63:0]        rsp_tag_low,
   output logic [63:0]        rsp_tag_high
);
   pma_pkg::state_type  state_ff, state_in;
   logic [2:0]          row_ff, row_in;
   pma_pkg::acc_type    acc_ff, acc_in, res_ff, res_in;
   logic [4:0][56:0]    prod_ff, prod_in;
   logic [33:0]         carry_ff, carry_in;
   logic                last_ff, last_in;
   logic [127:0]        tag_ff, tag_in;
   logic                full_ff, full_in;

   pma_pkg::acc_type    blk, w, t, sa;
   pma_pkg::chain_type  ch, cw, cs;
   pma_pkg::coef_type   coef;
   logic [59:0]         x;
   logic [36:0]         ov;
   logic [2:0]          idx;

   assign rsp_empty    = !full_ff;
   assign rsp_tag_low  = tag_ff[63:0];
   assign rsp_tag_high = tag_ff[127:64];

   // coefficient for product acc[j] in the current row
   always_comb begin
      for (int j = 0; j < pma_pkg::LIMBS; j++) begin
         if (3'(j) <= row_ff) begin
            coef[j] = key.r[3'(row_ff - 3'(j))];
         end else begin
            coef[j] = key.r5[3'(row_ff + 3'd5 - 3'(j))];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      acc_in   = acc_ff;
      res_in   = res_ff;
      prod_in  = prod_ff;
      carry_in = carry_ff;
      last_in  = last_ff;
      tag_in   = tag_ff;
      full_in  = full_ff;
      q_pop    = 1'b0;
      blk      = pma_pkg::split128(q_entry.data);
      x        = 60'(prod_ff[0]) + 60'(prod_ff[1]) + 60'(prod_ff[2]) + 60'(prod_ff[3])
                 + 60'(prod_ff[4]) + 60'(carry_ff);
      ov       = 37'(carry_ff) * 37'd5 + 37'(res_ff[0]);
      idx      = 3'(row_ff - 3'd1);
      w        = acc_ff;
      w[0]     = acc_ff[0] + 28'd5;
      ch       = pma_pkg::carry_chain(acc_ff);
      cw       = pma_pkg::carry_chain(w);
      sa       = pma_pkg::split128(key.s);
      for (int i = 0; i < pma_pkg::LIMBS; i++) begin
         t[i] = acc_ff[i] + sa[i];
      end
      cs       = pma_pkg::carry_chain(t);

      if (rsp_pop && full_ff) begin
         full_in = 1'b0;
      end

      case (state_ff)
         pma_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               last_in  = q_entry.last;
               row_in   = 3'd0;
               carry_in = '0;
               if (q_entry.has_block) begin
                  for (int i = 0; i < pma_pkg::LIMBS; i++) begin
                     acc_in[i] = acc_ff[i] + blk[i];
                  end
                  if (q_entry.high_bit) begin
                     acc_in[4] = acc_ff[4] + blk[4] + 28'(1 << 24);
                  end
                  state_in = pma_pkg::ST_MUL;
               end else begin
                  state_in = pma_pkg::ST_RED1;
               end
            end
         end
         pma_pkg::ST_MUL: begin
            for (int j = 0; j < pma_pkg::LIMBS; j++) begin
               prod_in[j] = 57'(acc_ff[j]) * 57'(coef[j]);
            end
            if (row_ff != 3'd0) begin
               res_in[idx] = {2'b0, x[25:0]};
               carry_in    = x[59:26];
            end
            row_in = row_ff + 3'd1;
            if (row_ff == 3'd5) begin
               state_in = pma_pkg::ST_FIX;
            end
         end
         pma_pkg::ST_FIX: begin
            acc_in[0] = {2'b0, ov[25:0]};
            acc_in[1] = res_ff[1] + 28'(ov[36:26]);
            acc_in[2] = res_ff[2];
            acc_in[3] = res_ff[3];
            acc_in[4] = res_ff[4];
            state_in  = last_ff ? pma_pkg::ST_RED1 : pma_pkg::ST_IDLE;
         end
         pma_pkg::ST_RED1: begin
            acc_in    = ch.l;
            acc_in[0] = ch.l[0] + 28'(ch.c) * 28'd5;
            state_in  = pma_pkg::ST_RED2;
         end
         pma_pkg::ST_RED2: begin
            acc_in   = ch.l;
            state_in = pma_pkg::ST_RED3;
         end
         pma_pkg::ST_RED3: begin
            if (cw.c != 3'd0) begin
               acc_in = cw.l;
            end
            state_in = pma_pkg::ST_OUT;
         end
         pma_pkg::ST_OUT: begin
            if (!full_ff) begin
               tag_in   = {cs.l[4][23:0], cs.l[3][25:0], cs.l[2][25:0],
                           cs.l[1][25:0], cs.l[0][25:0]};
               full_in  = 1'b1;
               acc_in   = '0;
               state_in = pma_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pma_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pma_pkg::ST_IDLE;
         full_ff  <= 1'b0;
         acc_ff   <= '0;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         full_ff  <= full_in;
         acc_ff   <= acc_in;
         row_ff   <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff   <= res_in;
      prod_ff  <= prod_in;
      carry_ff <= carry_in;
      last_ff  <= last_in;
      tag_ff   <= tag_in;
   end

endmodule

[bench/poly1305_mac_accumulator_top_tb.sv]
// Self-checking testbench for the Poly1305 accumulator: directed and random messages checked against a tag predictor.
module poly1305_mac_accumulator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [259:0] PRIME = (260'd1 << 130) - 260'd5;
   localparam int DRAIN_CYCLES = 40;
   localparam longint CYCLE_LIMIT = 2000000;

   typedef struct {
      logic [63:0] lo;
      logic [63:0] hi;
      logic [4:0]  count;
      logic        last;
   } block_type;

   typedef struct {
      logic [63:0] lo;
      logic [63:0] hi;
   } tag_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [63:0] req_block_low = '0;
   logic [63:0] req_block_high = '0;
   logic [4:0]  req_byte_count = '0;
   logic        req_last_block = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [63:0] rsp_tag_low;
   logic [63:0] rsp_tag_high;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   block_type   pending_blocks[$];
   tag_type     expected_tags[$];
   int          errors = 0;
   int          idle_mode = 0;
   int          hold_left = 0;
   longint      cycles = 0;

   logic [259:0] acc_value = '0;
   logic [127:0] r_clamped = '0;
   logic [127:0] s_value = '0;
   logic         aead = 1'b0;
   logic [127:0] r_raw = '0;

   poly1305_mac_accumulator_top dut (.*);

   always #5 clock = ~clock;

   function automatic void absorb_block(block_type b);
      logic [259:0] val;
      int n;
      tag_type t;
      n = (b.count > 16) ? 16 : b.count;
      if (n > 0) begin
         val = {132'd0, b.hi, b.lo} & ((260'd1 << (8 * n)) - 260'd1);
         if (n == 16 || aead)
            val[128] = 1'b1;
         else
            val[8 * n] = 1'b1;
         acc_value = ((acc_value + val) * {132'd0, r_clamped}) % PRIME;
      end
      if (b.last) begin
         val = acc_value + {132'd0, s_value};
         t.lo = val[63:0];
         t.hi = val[127:64];
         expected_tags = {expected_tags, t};
         acc_value = '0;
      end
   endfunction

   always @(posedge clock) begin
      logic send;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
      if (!reset) begin
         if (req_push && !req_full)
            absorb_block(pending_blocks.pop_front());
         send = pending_blocks.size() > 0 &&
                !(idle_mode == 0 && $urandom_range(99) < 15) &&
                !(idle_mode == 1 && $urandom_range(99) < 76);
         req_push <= send;
         if (send) begin
            req_block_low  <= pending_blocks[0].lo;
            req_block_high <= pending_blocks[0].hi;
            req_byte_count <= pending_blocks[0].count;
            req_last_block <= pending_blocks[0].last;
         end
      end
   end

   always @(posedge clock) begin
      tag_type t;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_tags.size() == 0) begin
               $error("unexpected tag %h_%h", rsp_tag_high, rsp_tag_low);
               errors++;
            end else begin
               t = expected_tags.pop_front();
               if (rsp_tag_low !== t.lo) begin
                  $error("tag_low: expected %h, got %h", t.lo, rsp_tag_low);
                  errors++;
               end
               if (rsp_tag_high !== t.hi) begin
                  $error("tag_high: expected %h, got %h", t.hi, rsp_tag_high);
                  errors++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= !(idle_mode == 0 && $urandom_range(99) < 76) &&
                       !(idle_mode == 1 && $urandom_range(99) < 15);
         end
      end
   end

   task automatic write_reg(pma_pkg::csr_index_type idx, logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         pma_pkg::REG_R_LOW:  r_raw[63:0] = value;
         pma_pkg::REG_R_HIGH: r_raw[127:64] = value;
         pma_pkg::REG_S_LOW:  s_value[63:0] = value;
         pma_pkg::REG_S_HIGH: s_value[127:64] = value;
         pma_pkg::REG_AEAD:   aead = value[0];
         default: ;
      endcase
      r_clamped = r_raw & 128'h0ffffffc0ffffffc0ffffffc0fffffff;
   endtask

   task automatic set_keys(logic [63:0] rl, rh, sl, sh, logic mode);
      write_reg(pma_pkg::REG_R_LOW, rl);
      write_reg(pma_pkg::REG_R_HIGH, rh);
      write_reg(pma_pkg::REG_S_LOW, sl);
      write_reg(pma_pkg::REG_S_HIGH, sh);
      write_reg(pma_pkg::REG_AEAD, {63'd0, mode});
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_blocks.size() > 0 || expected_tags.size() > 0 || req_push);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic void add_block(logic [63:0] lo, hi, logic [4:0] count, logic last);
      block_type b;
      b.lo = lo;
      b.hi = hi;
      b.count = count;
      b.last = last;
      pending_blocks = {pending_blocks, b};
   endfunction

   function automatic int add_random_traffic(int target);
      int produced;
      int len;
      produced = 0;
      while (produced < target) begin
         if ($urandom_range(9) == 0) begin
            add_block(rand64(), rand64(), 5'($urandom_range(31)), 1'($urandom_range(1)));
            produced++;
         end else begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len - 1; i++)
               add_block(rand64(), rand64(), ($urandom_range(7) == 0) ?
                         5'($urandom_range(1, 16)) : 5'd16, 1'b0);
            add_block(rand64(), rand64(), 5'($urandom_range(16)), 1'b1);
            produced += len;
         end
      end
      add_block(rand64(), rand64(), 5'd16, 1'b1);
      return produced + 1;
   endfunction

   initial begin
      int sent;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_keys(rand64(), rand64(), rand64(), rand64(), 1'b0);
      // directed: padding lengths, empty blocks, saturated count, extreme data
      add_block('1, '1, 5'd16, 1'b0);
      add_block('0, '0, 5'd0, 1'b0);
      add_block('1, '1, 5'd1, 1'b0);
      add_block('1, '1, 5'd7, 1'b0);
      add_block('1, '1, 5'd8, 1'b0);
      add_block('1, '1, 5'd9, 1'b0);
      add_block('1, '1, 5'd15, 1'b1);
      add_block('0, '0, 5'd0, 1'b1);
      add_block('1, '1, 5'd17, 1'b0);
      add_block('1, '1, 5'd31, 1'b1);
      add_block('0, '0, 5'd16, 1'b1);
      add_block(rand64(), rand64(), 5'd12, 1'b1);
      wait_idle();
      set_keys('1, '1, '1, '1, 1'b1);
      add_block('1, '1, 5'd16, 1'b0);
      add_block('1, '1, 5'd5, 1'b0);
      add_block('1, '1, 5'd8, 1'b1);
      add_block('0, '0, 5'd0, 1'b1);
      add_block('1, '1, 5'd3, 1'b1);
      sent = 0;
      for (int ph = 0; ph < 6; ph++) begin
         wait_idle();
         idle_mode = ph / 2;
         case (ph)
            0: set_keys('0, '0, '0, '0, 1'b0);
            1: set_keys('1, '1, '1, '1, 1'b0);
            2: set_keys(rand64(), rand64(), rand64(), rand64(), 1'b1);
            default: set_keys(rand64(), rand64(), rand64(), rand64(), 1'($urandom_range(1)));
         endcase
         if (ph == 1)
            hold_left = 400;
         sent += add_random_traffic(200);
      end
      wait_idle();
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
